// ----- design/assert_macros.svh -----
// Assertion macros shared by the extractor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define LSE_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define LSE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/lse_pkg.sv -----
// Types and constants of the LSB message extractor.
`default_nettype none

package lse_pkg;

  localparam int CH_W          = 8;
  localparam int PIXEL_COUNT_W = 27;
  localparam int CAP3_W        = PIXEL_COUNT_W + 2;
  localparam int STATUS_W      = 2;

  localparam logic [STATUS_W-1:0] ST_DATA  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic            first_pixel;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                last_byte;
    logic [CH_W-1:0]     message_byte;
  } result_t;

endpackage

`default_nettype wire

// ----- design/lse_in_stage.sv -----
// Input register of the extractor: holds one pixel word for the parser.
`default_nettype none

module lse_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,
  input  logic                       in_tuser,
  input  logic                       take,
  output logic                       pix_valid,
  output lse_pkg::pixel_t            pixel
);
  import lse_pkg::*;

  logic   valid_r, valid_nxt;
  pixel_t pixel_r;

  assign in_tready = !valid_r || take;
  assign pix_valid = valid_r;
  assign pixel     = pixel_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pixel_r.red         <= in_tdata[7:0];
      pixel_r.green       <= in_tdata[15:8];
      pixel_r.blue        <= in_tdata[23:16];
      pixel_r.first_pixel <= in_tuser;
    end
  end

endmodule

`default_nettype wire

// ----- design/lse_parser.sv -----
// Header and message parser: consumes three hidden bits per pixel word.
`default_nettype none
`include "assert_macros.svh"

module lse_parser #(
  parameter int HEADER_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [lse_pkg::PIXEL_COUNT_W-1:0]   cfg_wr_data,
  input  logic                                fire,
  input  lse_pkg::pixel_t                     pixel,
  output logic                                res_valid,
  output lse_pkg::result_t                    res
);
  import lse_pkg::*;

  localparam int HC_W  = $clog2(HEADER_BITS + 1);
  localparam int BL_W  = HEADER_BITS - 3;
  localparam int CMP_W = ((HEADER_BITS > CAP3_W) ? HEADER_BITS : CAP3_W) + 1;

  phase_t                  phase_r, phase_nxt, ph_eff;
  logic [HC_W-1:0]         hc_r, hc_eff, hc_nxt, hdr_rem;
  logic [HEADER_BITS-1:0]  len_r, len_eff, len_nxt;
  logic [BL_W-1:0]         bl_r, bl_nxt, hdr_bytes;
  logic [CH_W-1:0]         bs_r, bs_nxt, byte_v;
  logic [2:0]              bib_r, bib_nxt;
  logic [CAP3_W-1:0]       cap3_r;
  logic [2:0]              bits;
  logic [1:0]              k;
  logic [CMP_W-1:0]        need;
  logic                    hdr_done, hdr_pos, hdr_fits, hdr_go, hdr_empty;
  logic                    live, emit, emit_last;

  assign bits = {pixel.blue[0], pixel.green[0], pixel.red[0]};

  // Header bits first, then the length check on the completed header.
  always_comb begin
    ph_eff  = pixel.first_pixel ? PH_HEADER : phase_r;
    hc_eff  = pixel.first_pixel ? '0 : hc_r;
    len_eff = pixel.first_pixel ? '0 : len_r;
    hdr_rem = HC_W'(HEADER_BITS) - hc_eff;
    if (ph_eff != PH_HEADER) begin
      k = 2'd0;
    end else if (hdr_rem >= HC_W'(3)) begin
      k = 2'd3;
    end else begin
      k = hdr_rem[1:0];
    end
    len_nxt = len_eff;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < k) begin
        len_nxt = {len_nxt[HEADER_BITS-2:0], bits[i]};
      end
    end
    hc_nxt    = hc_eff + HC_W'(k);
    hdr_done  = (ph_eff == PH_HEADER) && (hc_nxt == HC_W'(HEADER_BITS));
    hdr_pos   = !len_nxt[HEADER_BITS-1] && (|len_nxt);
    need      = CMP_W'(len_nxt) + CMP_W'(HEADER_BITS);
    hdr_fits  = need <= CMP_W'(cap3_r);
    hdr_bytes = len_nxt[HEADER_BITS-1:3];
    hdr_go    = hdr_pos && hdr_fits && (|hdr_bytes);
    hdr_empty = hdr_pos && hdr_fits && !(|hdr_bytes);
  end

  // Message bits that follow, one byte at most per word.
  always_comb begin
    live      = (ph_eff == PH_DATA) || (hdr_done && hdr_go);
    bs_nxt    = hdr_done ? '0 : bs_r;
    bib_nxt   = hdr_done ? '0 : bib_r;
    bl_nxt    = hdr_done ? hdr_bytes : bl_r;
    emit      = 1'b0;
    emit_last = 1'b0;
    byte_v    = '0;
    for (int i = 0; i < 3; i++) begin
      if (live && (2'(i) >= k)) begin
        bs_nxt  = {bs_nxt[CH_W-2:0], bits[i]};
        bib_nxt = bib_nxt + 3'd1;
        if (bib_nxt == 3'd0) begin
          emit      = 1'b1;
          byte_v    = bs_nxt;
          emit_last = (bl_nxt == BL_W'(1));
          bl_nxt    = bl_nxt - BL_W'(1);
          if (emit_last) begin
            live = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    case (ph_eff)
      PH_HEADER: begin
        if (hdr_done) begin
          phase_nxt = hdr_go ? PH_DATA : PH_DONE;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_DATA: begin
        phase_nxt = emit_last ? PH_DONE : PH_DATA;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_comb begin
    res_valid        = (hdr_done && !hdr_go) || emit;
    res.message_byte = emit ? byte_v : '0;
    res.last_byte    = emit && emit_last;
    if (emit) begin
      res.status = ST_DATA;
    end else if (hdr_empty) begin
      res.status = ST_EMPTY;
    end else begin
      res.status = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap3_r <= '0;
    end else if (cfg_wr_en) begin
      cap3_r <= CAP3_W'({cfg_wr_data, 1'b0}) + CAP3_W'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hc_r    <= '0;
      len_r   <= '0;
      bl_r    <= '0;
      bs_r    <= '0;
      bib_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      len_r   <= len_nxt;
      bl_r    <= bl_nxt;
      bs_r    <= bs_nxt;
      bib_r   <= bib_nxt;
    end
  end

  `LSE_ASSERT_IMPLIES(a_hdr_count_range, clk, rst_n, phase_r == PH_HEADER, hc_r < HC_W'(HEADER_BITS), "header count past header length")
  `LSE_ASSERT_IMPLIES(a_data_has_bytes, clk, rst_n, phase_r == PH_DATA, bl_r != '0, "data phase with no bytes left")
  `LSE_ASSERT_NEXT(a_last_ends_msg, clk, rst_n, fire && emit_last, phase_r == PH_DONE, "last byte did not end the message")

endmodule

`default_nettype wire

// ----- design/lse_out_stage.sv -----
// Output register of the extractor: holds one result word until taken.
`default_nettype none

module lse_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  lse_pkg::result_t    res,
  output logic                slot_free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic [1:0]          out_tuser
);
  import lse_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign slot_free  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.message_byte;
  assign out_tlast  = res_r.last_byte;
  assign out_tuser  = res_r.status;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- design/lsb_stego_extractor_top.sv -----
// Top level of the LSB message extractor.
//
// Input channel: one pixel word per transfer. in_tdata carries red, green and
// blue; in_tuser marks the first pixel of an image and restarts parsing.
// The hidden bits are bit 0 of red, green, blue, taken in that order.
// The first HEADER_BITS hidden bits give the message length in bits.
// Result channel: at most one word per pixel. out_tdata is a message byte,
// out_tlast marks the final byte, out_tuser gives the status (data byte,
// no message, empty message). Status words carry a zero byte.
// cfg_wr_en writes pixel_count; write it only while the block is idle.
// The input transfer fills the input register; when the output register is
// free, the parser step loads any result word, which raises out_tvalid.
// Throughput: one pixel word per cycle unless the result channel stalls, set
// by the input and output registers around the combinational parser step.
// Reset clears both registers, the parser to the header phase and
// pixel_count to zero. When out_tready is low while a result is held, the
// parser stalls; in_tready drops when the full input register is not taken.
`default_nettype none

module lsb_stego_extractor_top #(
  parameter int HEADER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [26:0] cfg_wr_data,   // pixel_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // red [7:0], green [15:8], blue [23:16]
  input  logic        in_tuser,      // first_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // message_byte [7:0]
  output logic        out_tlast,     // last_byte
  output logic [1:0]  out_tuser      // status [1:0]
);
  import lse_pkg::*;

  logic    pix_valid, slot_free, fire, res_valid;
  pixel_t  pixel;
  result_t res;

  assign fire = pix_valid && slot_free;

  lse_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (fire),
    .pix_valid (pix_valid),
    .pixel     (pixel)
  );

  lse_parser #(
    .HEADER_BITS (HEADER_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .pixel       (pixel),
    .res_valid   (res_valid),
    .res         (res)
  );

  lse_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && res_valid),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
